[rtl/core/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// IR pulse-width frame decoder package
// Shared widths, register indexes, key codes, the configuration and result
// structures, and the key table lookup.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Field and state widths.
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned HighW    = 10;
  localparam int unsigned LowW     = 16;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned BitCntW  = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStartMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOneMin     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegZeroMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFrameBits  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegExpAddress = 3'd7;

  // High run limits.
  localparam logic [HighW-1:0] ForgetCount  = 10'd500;
  localparam logic [HighW-1:0] HighLimit    = 10'd1000;
  localparam logic [HighW-1:0] HighFallback = 10'd600;
  localparam logic [BitCntW-1:0] BitCountMax = 6'd63;

  // Key codes.
  localparam logic [2:0] KeyPower     = 3'd0;
  localparam logic [2:0] KeyWater     = 3'd1;
  localparam logic [2:0] KeyHeat      = 3'd2;
  localparam logic [2:0] KeyAdjTemp   = 3'd3;
  localparam logic [2:0] KeyKeepWarm  = 3'd4;
  localparam logic [2:0] KeyColdWater = 3'd5;

  typedef struct packed {
    logic [9:0] start_min;
    logic [9:0] start_max;
    logic [9:0] one_min;
    logic [9:0] one_max;
    logic [9:0] zero_min;
    logic [9:0] zero_max;
    logic [4:0] frame_bits;
    logic [3:0] expected_address;
  } cfg_t;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_data;
    logic [3:0]  address_nibble;
    logic [7:0]  command_byte;
    logic        key_valid;
    logic [2:0]  key_code;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } key_t;

  // Map a command byte onto its key code.
  function automatic key_t key_lookup(input logic [7:0] cmd);
    key_t k;
    k = '0;
    unique case (cmd)
      8'h81:   k = '{hit: 1'b1, code: KeyPower};
      8'hc3:   k = '{hit: 1'b1, code: KeyWater};
      8'h41:   k = '{hit: 1'b1, code: KeyHeat};
      8'h11:   k = '{hit: 1'b1, code: KeyAdjTemp};
      8'h21:   k = '{hit: 1'b1, code: KeyKeepWarm};
      8'h09:   k = '{hit: 1'b1, code: KeyColdWater};
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/irpd_cfg.sv]
// ----------------------------------------------------------------------------
// IR decoder configuration registers
// Holds the eight timing and frame registers, written through a plain
// write port and masked to their widths.
// ----------------------------------------------------------------------------
module irpd_cfg import irpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Register file with reset defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min        <= 10'd80;
      cfg_q.start_max        <= 10'd100;
      cfg_q.one_min          <= 10'd50;
      cfg_q.one_max          <= 10'd80;
      cfg_q.zero_min         <= 10'd18;
      cfg_q.zero_max         <= 10'd45;
      cfg_q.frame_bits       <= 5'd12;
      cfg_q.expected_address <= 4'd11;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegStartMin:   cfg_q.start_min        <= cfg_wdata_i;
        RegStartMax:   cfg_q.start_max        <= cfg_wdata_i;
        RegOneMin:     cfg_q.one_min          <= cfg_wdata_i;
        RegOneMax:     cfg_q.one_max          <= cfg_wdata_i;
        RegZeroMin:    cfg_q.zero_min         <= cfg_wdata_i;
        RegZeroMax:    cfg_q.zero_max         <= cfg_wdata_i;
        RegFrameBits:  cfg_q.frame_bits       <= cfg_wdata_i[4:0];
        RegExpAddress: cfg_q.expected_address <= cfg_wdata_i[3:0];
        default:       cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/irpd_core.sv]
// ----------------------------------------------------------------------------
// IR decoder run counters and frame assembly
// Keeps the high and low run counters, the shift buffer, the bit count and
// the last frame, and computes the result of one line sample.
// ----------------------------------------------------------------------------
module irpd_core import irpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  logic    level_i,
  output result_t result_o
);

  logic [HighW-1:0]   high_q, high_d;
  logic [LowW-1:0]    low_q, low_d;
  logic [FrameW-1:0]  sb_q, sb_d;
  logic [BitCntW-1:0] bc_q, bc_d;
  logic [FrameW-1:0]  lf_q, lf_d;

  logic [HighW-1:0]   high_inc, high_win;
  logic               in_start;
  logic [FrameW-1:0]  sb_win, sb_bit;
  logic [BitCntW-1:0] bc_win, bc_bit;
  logic [FrameW-1:0]  lf_win;
  logic               is_one, is_zero;
  logic [LowW-1:0]    low_inc;
  logic               frame_done;
  key_t               key;

  // Next state and result for the current sample.
  always_comb begin
    high_d   = high_q;
    low_d    = low_q;
    sb_d     = sb_q;
    bc_d     = bc_q;
    lf_d     = lf_q;
    result_o = '0;

    // High run: start window clears the frame under assembly.
    high_inc = high_q + 10'd1;
    in_start = (high_inc > cfg_i.start_min) && (high_inc < cfg_i.start_max);
    high_win = in_start ? cfg_i.start_max : high_inc;
    sb_win   = in_start ? '0 : sb_q;
    bc_win   = in_start ? '0 : bc_q;
    lf_win   = (high_win == ForgetCount) ? '0 : lf_q;

    // The low run that just ended decides the bit; the one window wins.
    is_one  = (low_q > LowW'(cfg_i.one_min)) && (low_q < LowW'(cfg_i.one_max));
    is_zero = !is_one && (low_q > LowW'(cfg_i.zero_min)) &&
              (low_q < LowW'(cfg_i.zero_max));
    sb_bit  = sb_win;
    bc_bit  = bc_win;
    if (is_one && (bc_win[5:4] == 2'b00)) begin
      sb_bit = sb_win | (FrameW'(1) << bc_win[3:0]);
    end
    if ((is_one || is_zero) && (bc_win != BitCountMax)) begin
      bc_bit = bc_win + 6'd1;
    end

    frame_done = (bc_bit >= BitCntW'(cfg_i.frame_bits)) && (sb_bit != lf_win);
    key        = key_lookup(sb_bit[11:4]);
    low_inc    = low_q + 16'd1;

    if (level_i) begin
      high_d = (high_win > HighLimit) ? HighFallback : high_win;
      low_d  = '0;
      sb_d   = sb_bit;
      bc_d   = bc_bit;
      lf_d   = lf_win;
      if (frame_done) begin
        lf_d                    = sb_bit;
        sb_d                    = '0;
        bc_d                    = '0;
        result_o.frame_valid    = 1'b1;
        result_o.frame_data     = sb_bit;
        result_o.address_nibble = sb_bit[3:0];
        result_o.command_byte   = sb_bit[11:4];
        if ((sb_bit[3:0] == cfg_i.expected_address) && key.hit) begin
          result_o.key_valid = 1'b1;
          result_o.key_code  = key.code;
        end
      end
    end else begin
      // Low run: a long enough gap ends the high run.
      low_d = low_inc;
      if (low_inc > LowW'(cfg_i.zero_min)) begin
        high_d = '0;
      end
    end
  end

  // State registers advance once per sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '0;
      low_q  <= '0;
      sb_q   <= '0;
      bc_q   <= '0;
      lf_q   <= '0;
    end else if (step_i) begin
      high_q <= high_d;
      low_q  <= low_d;
      sb_q   <= sb_d;
      bc_q   <= bc_d;
      lf_q   <= lf_d;
    end
  end

endmodule

[rtl/core/ir_pulse_width_frame_decoder.sv]
// ----------------------------------------------------------------------------
// IR pulse-width frame decoder
// Takes one sampled receiver level per transaction and returns one result
// per transaction: the frame fields when a new frame completes, zero else.
// ----------------------------------------------------------------------------
// The block accepts one line sample every clock cycle while the output is not
// held back, and returns exactly one result transaction per sample, in order.
// A sample goes into an input register, the run counters and frame logic act
// on it once the output register can be loaded, and the result lands in the
// output register, from which it can be taken at a clock edge
// when the output side is ready. The output register is loaded whenever it is
// empty or being taken, so input and output stall together only when the
// output is held back. Configuration writes take effect in the cycle after
// the write enable and should be issued while the block holds no sample in
// flight.
module ir_pulse_width_frame_decoder import irpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                line_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_valid_o,
  output logic [15:0]         frame_data_o,
  output logic [3:0]          address_nibble_o,
  output logic [7:0]          command_byte_o,
  output logic                key_valid_o,
  output logic [2:0]          key_code_o
);

  cfg_t    cfg;
  result_t step_res;
  result_t res_q;
  logic    s1_valid_q, s1_level_q;
  logic    out_valid_q;
  logic    out_load, step_en, in_fire;

  irpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step_en),
    .level_i  (s1_level_q),
    .result_o (step_res)
  );

  // Flow control between input register and output register.
  assign out_load   = !out_valid_q || out_ready_i;
  assign step_en    = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (step_en) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= line_level_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_valid_o    = res_q.frame_valid;
  assign frame_data_o     = res_q.frame_data;
  assign address_nibble_o = res_q.address_nibble;
  assign command_byte_o   = res_q.command_byte;
  assign key_valid_o      = res_q.key_valid;
  assign key_code_o       = res_q.key_code;

endmodule

[rtl/core/irpd_checker.sv]
// ----------------------------------------------------------------------------
// IR decoder port checker
// Watches the result channel of the decoder and checks that the reported
// fields agree with each other.
// ----------------------------------------------------------------------------
module irpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_valid_o,
  input logic [15:0] frame_data_o,
  input logic [3:0]  address_nibble_o,
  input logic [7:0]  command_byte_o,
  input logic        key_valid_o,
  input logic [2:0]  key_code_o
);

  // A key is only reported together with a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_valid_o) |-> frame_valid_o)
    else $error("key reported without a frame");

  // The address and command are slices of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (address_nibble_o == frame_data_o[3:0]) &&
                    (command_byte_o == frame_data_o[11:4]))
    else $error("address or command does not match frame data");

  // A result without a frame carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_valid_o) |-> (frame_data_o == 16'd0) &&
                                        !key_valid_o && (key_code_o == 3'd0))
    else $error("fields set in a result without a frame");

  // Key codes stay within the six known keys.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_valid_o) |-> (key_code_o <= 3'd5))
    else $error("key code out of range");

  // A held result stays on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind ir_pulse_width_frame_decoder irpd_checker u_irpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_valid_o    (frame_valid_o),
  .frame_data_o     (frame_data_o),
  .address_nibble_o (address_nibble_o),
  .command_byte_o   (command_byte_o),
  .key_valid_o      (key_valid_o),
  .key_code_o       (key_code_o)
);

[tb/ir_pulse_width_frame_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-width frame decoder testbench
// Feeds line samples through the valid/ready input and checks every result
// transaction against a cycle-free model of the decoder. A few samples under
// the register reset values and a short table of hand-built samples come
// first. They are followed by phases of random frames and noise under several
// register settings, including the extremes, a start window that forgets the
// last frame, a start window that reaches past the high limit and a
// saturating bit count. Both sides stall at random but in the first random phase.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder_tb;
  import irpd_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 8;
  localparam int IdlePct       = 25;

  // Command bytes of the key table, ordered by key code.
  localparam logic [7:0] KeyCmd [6] = '{8'h81, 8'hc3, 8'h41, 8'h11, 8'h21, 8'h09};

  // One row of the hand-built sample table.
  typedef struct packed {
    logic    level;
    logic    fixed;
    result_t want;
  } probe_t;

  localparam result_t NoFrame = '0;
  localparam result_t FrameD  = '{frame_valid: 1'b1, frame_data: 16'h000d,
                                  address_nibble: 4'hd, command_byte: 8'h00,
                                  key_valid: 1'b0, key_code: '0};

  // Built for the short timing profile: start burst, bits 1,0,1,1, then a
  // low run too long to count as any bit.
  localparam int DirRows = 24;
  localparam probe_t DirTab [DirRows] = '{
    '{1'b1, 1'b1, NoFrame},  // first sample under the short profile
    '{1'b1, 1'b0, NoFrame},
    '{1'b1, 1'b0, NoFrame},  // enters the start window
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b1, 1'b0, NoFrame},  // one bit
    '{1'b0, 1'b0, NoFrame},
    '{1'b1, 1'b0, NoFrame},  // zero bit
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b1, 1'b0, NoFrame},  // one bit
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b1, 1'b1, FrameD},   // fourth bit completes the frame
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b0, 1'b0, NoFrame},
    '{1'b1, 1'b0, NoFrame}   // low run outside both windows
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                line_level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                frame_valid_o;
  logic [15:0]         frame_data_o;
  logic [3:0]          address_nibble_o;
  logic [7:0]          command_byte_o;
  logic                key_valid_o;
  logic [2:0]          key_code_o;

  // Decoder model state and its copy of the registers.
  cfg_t               reg_copy;
  logic [HighW-1:0]   high_run;
  logic [LowW-1:0]    low_run;
  logic [FrameW-1:0]  shift_reg;
  logic [BitCntW-1:0] bits_in;
  logic [FrameW-1:0]  last_reported;

  result_t     decoded_q[$];
  int          mismatches;
  int          samples_sent;
  int          stalled;
  bit          no_idle;
  logic [15:0] prev_word;

  ir_pulse_width_frame_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .line_level_i     (line_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_valid_o    (frame_valid_o),
    .frame_data_o     (frame_data_o),
    .address_nibble_o (address_nibble_o),
    .command_byte_o   (command_byte_o),
    .key_valid_o      (key_valid_o),
    .key_code_o       (key_code_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Advance the decoder model by one line sample and return its result.
  function automatic result_t decode_sample(input logic lvl);
    result_t r;
    logic    take;
    logic    one;
    r    = '0;
    take = 1'b0;
    one  = 1'b0;
    if (lvl) begin
      high_run = high_run + 1'b1;
      // A high run inside the start window restarts the frame.
      if (high_run > reg_copy.start_min && high_run < reg_copy.start_max) begin
        high_run  = reg_copy.start_max;
        shift_reg = '0;
        bits_in   = '0;
      end
      if (high_run == ForgetCount) last_reported = '0;
      if (high_run > HighLimit) high_run = HighFallback;
      // The low run that just ended is a bit if its width fits a window.
      // The one window takes precedence.
      if (low_run > reg_copy.one_min && low_run < reg_copy.one_max) begin
        take = 1'b1;
        one  = 1'b1;
      end else if (low_run > reg_copy.zero_min && low_run < reg_copy.zero_max) begin
        take = 1'b1;
      end
      if (take) begin
        if (one && bits_in < 6'd16) shift_reg[bits_in[3:0]] = 1'b1;
        if (bits_in < BitCountMax) bits_in = bits_in + 1'b1;
      end
      low_run = '0;
      // Report a completed frame that differs from the previous one.
      if (bits_in >= reg_copy.frame_bits && shift_reg != last_reported) begin
        r.frame_valid    = 1'b1;
        r.frame_data     = shift_reg;
        r.address_nibble = shift_reg[3:0];
        r.command_byte   = shift_reg[11:4];
        if (shift_reg[3:0] == reg_copy.expected_address) begin
          for (int k = 0; k < 6; k++) begin
            if (!r.key_valid && shift_reg[11:4] == KeyCmd[k]) begin
              r.key_valid = 1'b1;
              r.key_code  = 3'(k);
            end
          end
        end
        last_reported = shift_reg;
        shift_reg     = '0;
        bits_in       = '0;
      end
    end else begin
      low_run = low_run + 1'b1;
      if (low_run > reg_copy.zero_min) high_run = '0;
    end
    return r;
  endfunction

  // Write one register and mirror it, masked to its width, in the model.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegStartMin:   reg_copy.start_min        = data;
      RegStartMax:   reg_copy.start_max        = data;
      RegOneMin:     reg_copy.one_min          = data;
      RegOneMax:     reg_copy.one_max          = data;
      RegZeroMin:    reg_copy.zero_min         = data;
      RegZeroMax:    reg_copy.zero_max         = data;
      RegFrameBits:  reg_copy.frame_bits       = data[4:0];
      RegExpAddress: reg_copy.expected_address = data[3:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] s_min, s_max, o_min, o_max,
                              z_min, z_max, f_bits, e_addr);
    write_reg(RegStartMin, s_min);
    write_reg(RegStartMax, s_max);
    write_reg(RegOneMin, o_min);
    write_reg(RegOneMax, o_max);
    write_reg(RegZeroMin, z_min);
    write_reg(RegZeroMax, z_max);
    write_reg(RegFrameBits, f_bits);
    write_reg(RegExpAddress, e_addr);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one sample, wait for its transaction and queue the expected result.
  task automatic send_sample(input logic lvl, input bit fixed = 1'b0,
                             input result_t want = '0);
    result_t predicted;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99, 0) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    line_level_i <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = decode_sample(lvl);
    decoded_q.push_back(fixed ? want : predicted);
    samples_sent++;
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_sample(lvl);
  endtask

  // Random width strictly between lo and hi, or just past lo if none fits.
  function automatic int width_between(input int lo, input int hi);
    if (hi > lo + 1) return $urandom_range(hi - 1, lo + 1);
    return lo + 1;
  endfunction

  // Line waveform of one frame under the current timing registers, first bit
  // at bit 0. Bits past sixteen are random.
  task automatic send_frame(input logic [15:0] word, input int nbits);
    logic b;
    // A low gap clears the high counter, then the start burst follows.
    send_run(1'b0, int'(reg_copy.zero_min) + 1 + $urandom_range(3, 0));
    send_run(1'b1, int'(reg_copy.start_min) + 1 + $urandom_range(2, 0));
    for (int i = 0; i < nbits; i++) begin
      b = (i < 16) ? word[i] : 1'($urandom_range(1, 0));
      if (b) send_run(1'b0, width_between(int'(reg_copy.one_min), int'(reg_copy.one_max)));
      else send_run(1'b0, width_between(int'(reg_copy.zero_min), int'(reg_copy.zero_max)));
      send_run(1'b1, ($urandom_range(3, 0) == 0) ? 2 : 1);
    end
  endtask

  // Mostly well-formed frames with random content, some cut short or overlong,
  // and random noise runs.
  task automatic random_traffic(input int budget);
    int          stop;
    int          pick;
    int          sel;
    int          nbits;
    logic [15:0] word;
    logic [3:0]  addr;
    stop = samples_sent + budget;
    while (samples_sent < stop) begin
      pick = $urandom_range(99, 0);
      if (pick < 83) begin
        sel = $urandom_range(9, 0);
        if (sel < 4) begin
          addr = (sel == 0) ? 4'($urandom_range(15, 0)) : reg_copy.expected_address;
          word = {4'h0, KeyCmd[$urandom_range(5, 0)], addr};
        end else if (sel < 5) begin
          word = prev_word;
        end else if (sel < 6) begin
          word = '0;
        end else begin
          word = 16'($urandom);
        end
        prev_word = word;
        if (pick < 65) nbits = int'(reg_copy.frame_bits);
        else if (pick < 80) nbits = $urandom_range(20, 0);
        else nbits = $urandom_range(24, 17);
        send_frame(word, nbits);
      end else begin
        send_run(1'($urandom_range(1, 0)),
                 ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1));
      end
    end
  endtask

  // Hold off the sender until every expected result is back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver readiness, with random stalls.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= no_idle || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual frame_data %h",
                 $time, frame_data_o);
      end else begin
        exp_r = decoded_q.pop_front();
        check_field("frame_valid", 16'(exp_r.frame_valid), 16'(frame_valid_o));
        check_field("frame_data", exp_r.frame_data, frame_data_o);
        check_field("address_nibble", 16'(exp_r.address_nibble), 16'(address_nibble_o));
        check_field("command_byte", 16'(exp_r.command_byte), 16'(command_byte_o));
        check_field("key_valid", 16'(exp_r.key_valid), 16'(key_valid_o));
        check_field("key_code", 16'(exp_r.key_code), 16'(key_code_o));
      end
    end
  end

  // End the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
    else stalled++;
    if (stalled >= WatchdogLimit) begin
      $display("ir_pulse_width_frame_decoder test failed");
      $finish;
    end
  end

  initial begin
    int s_min;
    int o_min;
    int z_min;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    line_level_i  = 1'b0;
    mismatches    = 0;
    samples_sent  = 0;
    stalled       = 0;
    no_idle       = 1'b0;
    prev_word     = '0;
    reg_copy      = '{start_min: 10'd80, start_max: 10'd100, one_min: 10'd50,
                      one_max: 10'd80, zero_min: 10'd18, zero_max: 10'd45,
                      frame_bits: 5'd12, expected_address: 4'd11};
    high_run      = '0;
    low_run       = '0;
    shift_reg     = '0;
    bits_in       = '0;
    last_reported = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register reset values: a zero bit, a short high run, then a gap long
    // enough to clear the high counter.
    send_run(1'b0, 20);
    send_run(1'b1, 3);
    send_run(1'b0, 25);

    // Short timing profile, four-bit frames, then the hand-built table.
    wait_idle();
    program_regs(10'd2, 10'd5, 10'd2, 10'd6, 10'd0, 10'd3, 10'd4, 10'd11);
    for (int r = 0; r < DirRows; r++)
      send_sample(DirTab[r].level, DirTab[r].fixed, DirTab[r].want);

    // Random frames, first without any stalls.
    no_idle = 1'b1;
    random_traffic(60);
    no_idle = 1'b0;
    random_traffic(30);

    // Twelve-bit frames carrying key commands, with narrow bit windows.
    wait_idle();
    program_regs(10'd2, 10'd5, 10'd1, 10'd3, 10'd0, 10'd2, 10'd12,
                 10'($urandom_range(15, 0)));
    random_traffic(50);

    // A wide start window: every start burst forgets the last frame.
    wait_idle();
    program_regs(10'd2, 10'd500, 10'd1, 10'd3, 10'd0, 10'd2, 10'd4, 10'd11);
    random_traffic(20);

    // A start window that reaches past the high limit: the high counter
    // falls back and every high sample after a gap restarts the frame.
    wait_idle();
    program_regs(10'd0, 10'd1023, 10'd1, 10'd3, 10'd0, 10'd2, 10'd1, 10'd11);
    random_traffic(20);

    // A forget, then an all-zero frame long enough to saturate the bit
    // count, and a one bit that falls outside the buffer.
    wait_idle();
    program_regs(10'd2, 10'd500, 10'd1, 10'd3, 10'd0, 10'd2, 10'd31, 10'd11);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    repeat (65) begin
      send_sample(1'b0);
      send_sample(1'b1);
    end
    send_run(1'b0, 2);
    send_run(1'b1, 1);

    // All registers at zero.
    wait_idle();
    program_regs('0, '0, '0, '0, '0, '0, '0, '0);
    random_traffic(15);

    // All registers at their maximum; frame bits and address are masked.
    wait_idle();
    program_regs('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (6) send_run(1'($urandom_range(1, 0)), $urandom_range(12, 1));

    // Zero frame bits: any change of the buffer is reported.
    wait_idle();
    program_regs(10'd2, 10'd5, 10'd2, 10'd6, 10'd0, 10'd3, 10'd0, 10'd0);
    random_traffic(20);

    // Random small timings, windows free to overlap.
    repeat (2) begin
      wait_idle();
      s_min = $urandom_range(6, 0);
      o_min = $urandom_range(8, 0);
      z_min = $urandom_range(4, 0);
      program_regs(10'(s_min), 10'(s_min + $urandom_range(5, 0)),
                   10'(o_min), 10'(o_min + $urandom_range(6, 0)),
                   10'(z_min), 10'(z_min + $urandom_range(6, 0)),
                   10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)));
      random_traffic(20);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("ir_pulse_width_frame_decoder test passed");
    end else begin
      $display("ir_pulse_width_frame_decoder test failed");
    end
    $finish;
  end

endmodule
